>>> rtl/lagged_fibonacci_ranged_rng_unit_assert.svh
// Assertion macros used by the RTL that checks itself.
`ifndef LAGGED_FIBONACCI_RANGED_RNG_UNIT_ASSERT_SVH
`define LAGGED_FIBONACCI_RANGED_RNG_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LFRR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfrr same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define LFRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfrr next-cycle check failed");

`endif

>>> rtl/lfrr_pkg.sv
`default_nettype none

package lfrr_pkg;

    localparam int TABLE_DEPTH  = 17;
    localparam int WORD_W       = 16;
    localparam int SPAN_W       = WORD_W + 1;
    localparam int SEED_COUNT   = 17;
    localparam int SECOND_START = 4;

    // Cell 0 always holds the entry at the first index; the second index
    // trails it by a fixed distance, so its entry sits at a fixed cell.
    localparam int LAG_CELL = TABLE_DEPTH - 1 - (SECOND_START % TABLE_DEPTH);

    typedef enum logic {
        REQ_DRAW   = 1'b0,
        REQ_RESEED = 1'b1
    } t_req;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic [WORD_W-1:0] acc;
        logic [SPAN_W-1:0] span;
    } t_scale_in;

    localparam logic [WORD_W-1:0] SEED_WORDS [SEED_COUNT] = '{
        16'd1,   16'd1,   16'd2,   16'd3,   16'd5,   16'd8,    16'd13,   16'd21,
        16'd54,  16'd75,  16'd129, 16'd204, 16'd323, 16'd527,  16'd850,  16'd1377,
        16'd2227
    };

    function automatic logic [WORD_W-1:0] table_word(input int k);
        logic [WORD_W-1:0] w;
        w = '0;
        if (k < SEED_COUNT) begin
            w = SEED_WORDS[k];
        end
        return w;
    endfunction

    // Cell k holds table entry (first_index - k), first_index starting at the top.
    function automatic logic [WORD_W-1:0] default_cell(input int k);
        return table_word(TABLE_DEPTH - 1 - k);
    endfunction

    localparam logic [WORD_W-1:0] RESEED_ACC = default_cell(0) + default_cell(LAG_CELL);

    // State after a reseed: default row shifted once, with the discarded sum on top.
    function automatic logic [WORD_W-1:0] reseed_cell(input int k);
        logic [WORD_W-1:0] w;
        w = RESEED_ACC;
        if (k < TABLE_DEPTH - 1) begin
            w = default_cell(k + 1);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lagged_fibonacci_ranged_rng_unit.sv
// Additive lagged-Fibonacci random source with a ranged output. One beat is
// taken per cycle while the output does not stall: at the input handshake the
// table cells and accumulator advance (one add of two fixed cells plus one
// accumulate) and the scale stage registers the new accumulator; the 16x17
// multiply fills the output register. A draw with bound 0 returns 0 and leaves
// the state alone; a reseed returns 0 and loads the default table already
// advanced by one draw. Reset loads the default state, with no clearing pass.
`default_nettype none

module lagged_fibonacci_ranged_rng_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_req_type,
    input  wire logic [lfrr_pkg::WORD_W-1:0]  i_max_val,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [lfrr_pkg::WORD_W-1:0]       o_value
);

    localparam int DEPTH = lfrr_pkg::TABLE_DEPTH;

    logic [lfrr_pkg::WORD_W-1:0] w_word [DEPTH];
    logic [lfrr_pkg::WORD_W-1:0] r_acc;
    logic [lfrr_pkg::WORD_W-1:0] n_acc;
    logic [lfrr_pkg::WORD_W-1:0] w_sum;
    logic                        w_take;
    logic                        w_draw;
    logic                        w_reseed;
    logic                        w_idle_draw;
    lfrr_pkg::t_cell_ctrl        w_ctrl;
    lfrr_pkg::t_scale_in         w_scale;

    assign w_take   = i_valid && o_ready;
    assign w_reseed = w_take && (i_req_type == lfrr_pkg::REQ_RESEED);
    assign w_draw   = w_take && (i_req_type == lfrr_pkg::REQ_DRAW) && (i_max_val != '0);

    assign w_idle_draw = w_take && (i_req_type == lfrr_pkg::REQ_DRAW) && (i_max_val == '0);

    assign w_ctrl.shift = w_draw;
    assign w_ctrl.load  = w_reseed;

    assign w_sum = w_word[0] + w_word[lfrr_pkg::LAG_CELL];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [lfrr_pkg::WORD_W-1:0] w_next;
        if (k == DEPTH - 1) begin : g_top
            assign w_next = w_sum;
        end else begin : g_mid
            assign w_next = w_word[k + 1];
        end

        lfrr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_init_word   (lfrr_pkg::default_cell(k)),
            .i_reseed_word (lfrr_pkg::reseed_cell(k)),
            .i_next_word   (w_next),
            .o_word        (w_word[k])
        );
    end

    always_comb begin
        n_acc = r_acc;
        if (w_reseed) begin
            n_acc = lfrr_pkg::RESEED_ACC;
        end else if (w_draw) begin
            n_acc = r_acc + w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Span 0 forces a zero result for a reseed.
    assign w_scale.acc  = n_acc;
    assign w_scale.span = (i_req_type == lfrr_pkg::REQ_RESEED) ? '0 :
                          lfrr_pkg::SPAN_W'(i_max_val) + lfrr_pkg::SPAN_W'(1);

    lfrr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (w_scale),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_value (o_value)
    );

`include "lagged_fibonacci_ranged_rng_unit_assert.svh"

    `LFRR_ASSERT_NEXT(a_zero_bound_holds, w_idle_draw, $stable(r_acc) && $stable(w_word[0]))
    `LFRR_ASSERT_NEXT(a_reseed_acc, w_reseed, r_acc == lfrr_pkg::RESEED_ACC)
    `LFRR_ASSERT_NEXT(a_reseed_top, w_reseed, w_word[DEPTH-1] == lfrr_pkg::RESEED_ACC)

endmodule

`default_nettype wire

>>> rtl/lfrr_cell.sv
`default_nettype none

module lfrr_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lfrr_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic [lfrr_pkg::WORD_W-1:0]      i_init_word,
    input  wire logic [lfrr_pkg::WORD_W-1:0]      i_reseed_word,
    input  wire logic [lfrr_pkg::WORD_W-1:0]      i_next_word,
    output logic      [lfrr_pkg::WORD_W-1:0]      o_word
);

    logic [lfrr_pkg::WORD_W-1:0] r_word;
    logic [lfrr_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.load) begin
            n_word = i_reseed_word;
        end else if (i_ctrl.shift) begin
            n_word = i_next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= i_init_word;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> rtl/lfrr_scale.sv
`default_nettype none

module lfrr_scale (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire lfrr_pkg::t_scale_in          i_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [lfrr_pkg::WORD_W-1:0]       o_value
);

    localparam int PROD_W = lfrr_pkg::WORD_W + lfrr_pkg::SPAN_W;

    logic                        r_a_valid;
    lfrr_pkg::t_scale_in         r_a;
    logic                        r_valid;
    logic [lfrr_pkg::WORD_W-1:0] r_value;
    logic                        w_adv_out;
    logic                        w_adv_a;
    logic [PROD_W-1:0]           w_product;

    assign w_adv_out = !r_valid || i_ready;
    assign w_adv_a   = !r_a_valid || w_adv_out;
    assign o_ready   = w_adv_a;

    // span is 0 for reseed, 1 for a zero bound, 65536 for full range
    assign w_product = PROD_W'(r_a.acc) * PROD_W'(r_a.span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= i_valid;
            end
            if (w_adv_out) begin
                r_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a <= i_data;
        end
        if (w_adv_out && r_a_valid) begin
            r_value <= w_product[lfrr_pkg::WORD_W +: lfrr_pkg::WORD_W];
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

`default_nettype wire
